// ----- hdl/sbc_pkg.sv -----
// shared constants and command codes for the stereo biquad cascade
package sbc_pkg;

  localparam int DEF_MAX_STAGES  = 33;
  localparam int DEF_SAMPLE_BITS = 24;
  localparam int DEF_COEFF_BITS  = 32;

  localparam int CFG_BITS   = 6;
  localparam int STAGE_BITS = 6;
  localparam int SEL_BITS   = 3;
  localparam int TAPS       = 5;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_LOAD   = 1'b1;

  localparam logic [SEL_BITS-1:0] SEL_B0 = 3'd0;
  localparam logic [SEL_BITS-1:0] SEL_B1 = 3'd1;
  localparam logic [SEL_BITS-1:0] SEL_B2 = 3'd2;
  localparam logic [SEL_BITS-1:0] SEL_A1 = 3'd3;
  localparam logic [SEL_BITS-1:0] SEL_A2 = 3'd4;
  localparam logic [SEL_BITS-1:0] SEL_EN = 3'd5;

endpackage

// ----- hdl/stereo_biquad_cascade.sv -----
// stereo direct-form-1 biquad cascade around one shared multiply-accumulate unit
//
//  channel | signals                                   | transfer when
//  --------+-------------------------------------------+---------------------------
//  config  | cfg_valid cfg_ready cfg_data              | cfg_valid && cfg_ready
//  input   | in_valid in_stall cmd left_in right_in    | in_valid && !in_stall
//          | stage_index coeff_select coeff_value      |
//  output  | out_valid out_stall left_out right_out    | out_valid && !out_stall
//
// a load item leaves the input free for the next item; a sample item is run through
// the enabled stages among the first active_stages, left channel then right, and a
// disabled stage is skipped; the single multiplier handles one tap per cycle, and no
// input is taken again until the result has gone to the output register.
// reset clears active_stages, the stage enables and the delay-line valid bits, so
// delay state reads as zero until a stage first runs; coefficients are undefined
// until loaded. in_stall is high during reset and while a sample is being worked on;
// a finished result waits in the output register and only the next result waits for it
module stereo_biquad_cascade #(
  parameter int MAX_STAGES  = sbc_pkg::DEF_MAX_STAGES,
  parameter int SAMPLE_BITS = sbc_pkg::DEF_SAMPLE_BITS,
  parameter int COEFF_BITS  = sbc_pkg::DEF_COEFF_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [sbc_pkg::CFG_BITS-1:0]       cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               cmd,
  input  logic signed [SAMPLE_BITS-1:0]      left_in,
  input  logic signed [SAMPLE_BITS-1:0]      right_in,
  input  logic [sbc_pkg::STAGE_BITS-1:0]     stage_index,
  input  logic [sbc_pkg::SEL_BITS-1:0]       coeff_select,
  input  logic signed [COEFF_BITS-1:0]       coeff_value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [SAMPLE_BITS-1:0]      left_out,
  output logic signed [SAMPLE_BITS-1:0]      right_out
);
  import sbc_pkg::*;

  // widths
  localparam int SW = $clog2(MAX_STAGES + 1);               // stage counter, holds the count
  localparam int SI = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;  // stage index
  localparam int CA = $clog2(MAX_STAGES * TAPS);            // coefficient address
  localparam int DA = SI + 1;                               // delay address {channel, stage}
  localparam int DD = 2 ** DA;
  localparam int SB = SAMPLE_BITS;
  localparam int MW = SB + 1;                               // negated sample fits
  localparam int PW = MW + COEFF_BITS;                      // exact product
  localparam int AW = PW + 3;                               // sum of five products
  localparam int CF = COEFF_BITS - 6;                       // coefficient fraction bits

  localparam logic signed [AW-1:0] TOP = {{(AW-SB+1){1'b0}}, {(SB-1){1'b1}}};
  localparam logic signed [AW-1:0] BOT = ~TOP;
  localparam logic signed [AW-1:0] RND = {{(AW-CF){1'b0}}, 1'b1, {(CF-1){1'b0}}};

  typedef enum logic [2:0] {
    S_IDLE, S_STAGE, S_MAC, S_FIN, S_CHAN, S_DONE
  } state_t;

  state_t                    state;
  logic [CFG_BITS-1:0]       active_stages;
  logic [SW-1:0]             n_act;
  logic [SW-1:0]             st;
  logic                      ch;
  logic [2:0]                k;
  logic signed [SB-1:0]      x;
  logic signed [SB-1:0]      right_hold;
  logic signed [SB-1:0]      left_res;
  logic [MAX_STAGES-1:0]     stage_en;
  logic [DD-1:0]             dly_valid;
  logic                      dly_ok;
  logic                      rd_v;
  logic [2:0]                rd_tap;
  logic                      mul_v;
  logic signed [PW-1:0]      prod;
  logic signed [AW-1:0]      acc;

  // memories
  logic signed [COEFF_BITS-1:0] coef_mem [MAX_STAGES*TAPS];
  logic signed [COEFF_BITS-1:0] coef_rdata;
  logic [4*SB-1:0]              dly_mem [DD];
  logic [4*SB-1:0]              dly_rdata;

  logic                      in_acc;
  logic                      stage_ok;
  logic                      coef_we;
  logic [CA-1:0]             coef_waddr;
  logic                      coef_re;
  logic [CA-1:0]             coef_raddr;
  logic [DA-1:0]             dly_addr;
  logic                      dly_re;
  logic                      dly_we;
  logic [4*SB-1:0]           dly_wdata;
  logic signed [SB-1:0]      x1, x2, y1, y2;
  logic signed [MW-1:0]      s_sel;
  logic signed [AW-1:0]      rsum, rsh;
  logic signed [SB-1:0]      r_clamp;
  logic                      st_live;

  assign cfg_ready = 1'b1;
  assign in_stall  = rst || (state != S_IDLE);
  assign in_acc    = in_valid && !in_stall;

  // load decode
  assign stage_ok   = ({1'b0, stage_index} < 7'(MAX_STAGES));
  assign coef_we    = in_acc && (cmd == CMD_LOAD) && stage_ok && (coeff_select < SEL_EN);
  assign coef_waddr = CA'({stage_index, 2'b00}) + CA'(stage_index) + CA'(coeff_select);

  // coefficient fetch, one tap per cycle
  assign coef_re    = (state == S_MAC) && (k < 3'(TAPS));
  assign coef_raddr = CA'({st, 2'b00}) + CA'(st) + CA'(k);

  // delay line access for the current channel and stage
  assign st_live   = (st < n_act);
  assign dly_addr  = {ch, st[SI-1:0]};
  assign dly_re    = (state == S_STAGE) && st_live && stage_en[st[SI-1:0]];
  assign dly_we    = (state == S_FIN);

  // rows never written read as zero
  assign x1 = dly_ok ? dly_rdata[4*SB-1:3*SB] : '0;
  assign x2 = dly_ok ? dly_rdata[3*SB-1:2*SB] : '0;
  assign y1 = dly_ok ? dly_rdata[2*SB-1:SB]   : '0;
  assign y2 = dly_ok ? dly_rdata[SB-1:0]      : '0;

  always_comb begin
    case (rd_tap)
      3'd0:    s_sel = MW'(x);
      3'd1:    s_sel = MW'(x1);
      3'd2:    s_sel = MW'(x2);
      3'd3:    s_sel = -MW'(y1);
      3'd4:    s_sel = -MW'(y2);
      default: s_sel = '0;
    endcase
  end

  // round half up, then clamp to the sample range
  assign rsum = acc + RND;
  assign rsh  = rsum >>> CF;
  always_comb begin
    if (rsh > TOP) begin
      r_clamp = TOP[SB-1:0];
    end else if (rsh < BOT) begin
      r_clamp = BOT[SB-1:0];
    end else begin
      r_clamp = rsh[SB-1:0];
    end
  end

  assign dly_wdata = {x, x1, r_clamp, y1};

  always_ff @(posedge clk) begin
    if (coef_we) begin
      coef_mem[coef_waddr] <= coeff_value;
    end
    if (coef_re) begin
      coef_rdata <= coef_mem[coef_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (dly_we) begin
      dly_mem[dly_addr] <= dly_wdata;
    end
    if (dly_re) begin
      dly_rdata <= dly_mem[dly_addr];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      active_stages <= '0;
      stage_en      <= '0;
      dly_valid     <= '0;
      out_valid     <= 1'b0;
      rd_v          <= 1'b0;
      mul_v         <= 1'b0;
      ch            <= 1'b0;
      st            <= '0;
      n_act         <= '0;
      k             <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        active_stages <= cfg_data;
      end
      // output register: load a finished result, or drop a transferred one
      if (state == S_DONE && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (cmd == CMD_LOAD) begin
              if (stage_ok && coeff_select == SEL_EN) begin
                stage_en[stage_index[SI-1:0]] <= coeff_value[0];
              end
            end else begin
              x          <= left_in;
              right_hold <= right_in;
              ch         <= 1'b0;
              st         <= '0;
              n_act      <= ({1'b0, active_stages} > 7'(MAX_STAGES)) ?
                            SW'(MAX_STAGES) : SW'(active_stages);
              state      <= S_STAGE;
            end
          end
        end

        S_STAGE: begin
          if (!st_live) begin
            state <= S_CHAN;
          end else if (stage_en[st[SI-1:0]]) begin
            dly_ok <= dly_valid[dly_addr];
            acc    <= '0;
            k      <= '0;
            rd_v   <= 1'b0;
            mul_v  <= 1'b0;
            state  <= S_MAC;
          end else begin
            st <= st + 1'b1;
          end
        end

        S_MAC: begin
          // fetch, multiply and accumulate are registered one after another
          rd_v   <= (k < 3'(TAPS));
          rd_tap <= k;
          mul_v  <= rd_v;
          if (rd_v) begin
            prod <= s_sel * coef_rdata;
          end
          if (mul_v) begin
            acc <= acc + AW'(prod);
          end
          k <= k + 1'b1;
          if (k == 3'(TAPS + 1)) begin
            state <= S_FIN;
          end
        end

        S_FIN: begin
          x                   <= r_clamp;
          dly_valid[dly_addr] <= 1'b1;
          st                  <= st + 1'b1;
          state               <= S_STAGE;
        end

        S_CHAN: begin
          if (!ch) begin
            left_res <= x;
            x        <= right_hold;
            ch       <= 1'b1;
            st       <= '0;
            state    <= S_STAGE;
          end else begin
            state <= S_DONE;
          end
        end

        S_DONE: begin
          if (!out_valid || !out_stall) begin
            left_out  <= left_res;
            right_out <= x;
            state     <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
